// File: rtl/fat12_chain_sector_walker_defines.svh
// assertion macros for the fat12 chain sector walker
`ifndef FAT12_CHAIN_SECTOR_WALKER_DEFINES_SVH
`define FAT12_CHAIN_SECTOR_WALKER_DEFINES_SVH

// same-cycle implication
`define FCSW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcsw assertion failed");

// next-cycle implication
`define FCSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcsw assertion failed");

`endif

// File: rtl/fcsw_pkg.sv
// shared types and constants of the fat12 chain sector walker
package fcsw_pkg;

  localparam int FCSW_FAT_BYTES    = 8192;
  localparam int FCSW_SECTOR_BYTES = 512;
  localparam int FCSW_SECTOR_SHIFT = $clog2(FCSW_SECTOR_BYTES);
  localparam int FCSW_DIR_PER_SEC  = FCSW_SECTOR_BYTES / 32;
  localparam int FCSW_DIV_BITS     = 24;
  localparam int FCSW_DSR_BITS     = 7;

  localparam logic [11:0] FCSW_FIRST_DATA = 12'h002;
  localparam logic [11:0] FCSW_LAST_DATA  = 12'hff6;

  localparam logic [1:0] REQ_LOAD     = 2'd0;
  localparam logic [1:0] REQ_START    = 2'd1;
  localparam logic [1:0] REQ_CONTINUE = 2'd2;

  localparam logic [2:0] REG_RESERVED = 3'd0;
  localparam logic [2:0] REG_COPIES   = 3'd1;
  localparam logic [2:0] REG_FAT_SIZE = 3'd2;
  localparam logic [2:0] REG_ROOT_CNT = 3'd3;
  localparam logic [2:0] REG_SPC      = 3'd4;
  localparam logic [2:0] REG_SPT      = 3'd5;
  localparam logic [2:0] REG_SIDES    = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FAT_RD0,
    ST_FAT_RD1,
    ST_FAT_RD2,
    ST_CL_MUL,
    ST_CL_ADD,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_DIV2_GO,
    ST_DIV2_WAIT,
    ST_EMIT,
    ST_EMPTY
  } fcsw_state_t;

  typedef struct packed {
    logic                     start;
    logic [FCSW_DIV_BITS-1:0] dividend;
    logic [FCSW_DSR_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic [FCSW_DIV_BITS-1:0] quotient;
    logic [FCSW_DSR_BITS-1:0] remainder;
  } div_rsp_t;

endpackage

// File: rtl/fat12_chain_sector_walker.sv
// top level: fat12 cluster chain walker with sector address split
//  channel | dir | handshake           | payload
//  in      | in  | in_valid / in_stall | req_type, fat_address, fat_value, first_cluster, byte_count
//  out     | out | out_valid/out_stall | sector_valid .. chain_error
//  cfg     | in  | cfg_write           | cfg_index, cfg_data
// a load is written to the fat store when accepted; a start computes the cluster's first sector,
// and a continue first reads the next fat entry; an empty or error result is emitted from the empty state
// each sector then takes two passes of the shared divider and one emit
// synchronous reset restores the geometry defaults and drops any walk
// the fat store holds whatever was last loaded; no clearing pass
// in_stall is high during reset and while a request is worked on; out_stall holds the sequencer
`include "fat12_chain_sector_walker_defines.svh"
module fat12_chain_sector_walker import fcsw_pkg::*; #(
  parameter int FAT_BYTES = FCSW_FAT_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [12:0] fat_address,
  input  logic [7:0]  fat_value,
  input  logic [11:0] first_cluster,
  input  logic [31:0] byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        sector_valid,
  output logic [23:0] logical_sector,
  output logic [23:0] cylinder,
  output logic        head,
  output logic [5:0]  track_sector,
  output logic        last_of_run,
  output logic        chain_done,
  output logic        chain_error,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(FAT_BYTES);

  logic [15:0] reserved_sectors;
  logic [2:0]  fat_copies;
  logic [4:0]  fat_size_sectors;
  logic [11:0] root_entry_count;
  logic [6:0]  sectors_per_cluster;
  logic [5:0]  sectors_per_track;
  logic [1:0]  side_count;

  fcsw_state_t state, state_next;

  logic [11:0] current_cluster;
  logic [31:0] bytes_left;
  logic        walk_active;
  logic [7:0]  fat_lo;
  logic [23:0] base;
  logic [18:0] cl_off;
  logic [23:0] lsn;
  logic [6:0]  nsec;
  logic [6:0]  k;
  logic        walk_done;
  logic        empty_done;
  logic        empty_err;
  logic [23:0] cyl;
  logic [6:0]  cyl_rem;

  logic        in_acc;
  logic        out_free;
  logic        out_load;
  logic        k_last;
  logic [6:0]  spc;
  logic [5:0]  spt;
  logic [1:0]  sides;
  logic [6:0]  per_cyl;
  logic [12:0] fat_off;
  logic        off_bad;
  logic [15:0] fat_word;
  logic [11:0] next_cl;
  logic        next_ok;
  logic        start_ok;
  logic [15:0] cl_bytes;
  logic [31:0] take;
  logic        mem_we;
  logic [AW-1:0] mem_raddr;
  logic [7:0]  mem_rdata;
  div_req_t    dreq;
  div_rsp_t    drsp;

  // geometry clamps
  always_comb begin
    if (sectors_per_cluster == 7'd0) begin
      spc = 7'd1;
    end else if (sectors_per_cluster > 7'd64) begin
      spc = 7'd64;
    end else begin
      spc = sectors_per_cluster;
    end
    spt = (sectors_per_track == 6'd0) ? 6'd1 : sectors_per_track;
    if (side_count == 2'd0) begin
      sides = 2'd1;
    end else if (side_count == 2'd3) begin
      sides = 2'd2;
    end else begin
      sides = side_count;
    end
    per_cyl  = (sides == 2'd2) ? {spt, 1'b0} : {1'b0, spt};
    cl_bytes = 16'({spc, FCSW_SECTOR_SHIFT'(0)});
    take     = (bytes_left > {16'd0, cl_bytes}) ? {16'd0, cl_bytes} : bytes_left;
  end

  always_comb begin
    in_acc   = in_valid && !in_stall;
    out_free = !out_valid || !out_stall;
    k_last   = (k + 7'd1) == nsec;
    fat_off  = {1'b0, current_cluster} + {2'b0, current_cluster[11:1]};
    off_bad  = ({1'b0, fat_off} + 14'd1) >= 14'(FAT_BYTES);
    fat_word = {mem_rdata, fat_lo};
    next_cl  = current_cluster[0] ? fat_word[15:4] : fat_word[11:0];
    next_ok  = (next_cl >= FCSW_FIRST_DATA) && (next_cl <= FCSW_LAST_DATA);
    start_ok = (first_cluster >= FCSW_FIRST_DATA) && (first_cluster <= FCSW_LAST_DATA);
    mem_we   = in_acc && (req_type == REQ_LOAD) && ({1'b0, fat_address} < 14'(FAT_BYTES));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (req_type == REQ_START) begin
            state_next = ((byte_count == 32'd0) || !start_ok) ? ST_EMPTY : ST_CL_MUL;
          end else if (req_type == REQ_CONTINUE) begin
            state_next = (!walk_active || off_bad) ? ST_EMPTY : ST_FAT_RD0;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FAT_RD0:   state_next = ST_FAT_RD1;
      ST_FAT_RD1:   state_next = ST_FAT_RD2;
      ST_FAT_RD2:   state_next = next_ok ? ST_CL_MUL : ST_EMPTY;
      ST_CL_MUL:    state_next = ST_CL_ADD;
      ST_CL_ADD:    state_next = ST_DIV1_GO;
      ST_DIV1_GO:   state_next = ST_DIV1_WAIT;
      ST_DIV1_WAIT: state_next = drsp.done ? ST_DIV2_GO : ST_DIV1_WAIT;
      ST_DIV2_GO:   state_next = ST_DIV2_WAIT;
      ST_DIV2_WAIT: state_next = drsp.done ? ST_EMIT : ST_DIV2_WAIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = k_last ? ST_IDLE : ST_DIV1_GO;
        end
      end
      ST_EMPTY:     state_next = out_free ? ST_IDLE : ST_EMPTY;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall      = 1'b1;
    out_load      = 1'b0;
    mem_raddr     = fat_off[AW-1:0];
    dreq.start    = 1'b0;
    dreq.dividend = lsn;
    dreq.divisor  = per_cyl;
    unique case (state)
      ST_IDLE:    in_stall = rst;
      ST_FAT_RD1: mem_raddr = AW'(fat_off + 13'd1);
      ST_DIV1_GO: dreq.start = 1'b1;
      ST_DIV2_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = {17'd0, cyl_rem};
        dreq.divisor  = {1'b0, spt};
      end
      ST_EMIT, ST_EMPTY: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      reserved_sectors <= 16'd1;
      fat_copies       <= 3'd2;
      fat_size_sectors <= 5'd2;
      root_entry_count <= 12'd112;
      sectors_per_cluster <= 7'd2;
      sectors_per_track   <= 6'd9;
      side_count       <= 2'd2;
      current_cluster  <= '0;
      bytes_left       <= '0;
      walk_active      <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_RESERVED: reserved_sectors    <= cfg_data;
          REG_COPIES:   fat_copies          <= cfg_data[2:0];
          REG_FAT_SIZE: fat_size_sectors    <= cfg_data[4:0];
          REG_ROOT_CNT: root_entry_count    <= cfg_data[11:0];
          REG_SPC:      sectors_per_cluster <= cfg_data[6:0];
          REG_SPT:      sectors_per_track   <= cfg_data[5:0];
          REG_SIDES:    side_count          <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (state == ST_IDLE && in_acc) begin
        if (req_type == REQ_START) begin
          bytes_left  <= byte_count;
          walk_active <= (byte_count != 32'd0) && start_ok;
          if (start_ok) begin
            current_cluster <= first_cluster;
          end
        end else if (req_type == REQ_CONTINUE && off_bad) begin
          walk_active <= 1'b0;
        end
      end
      if (state == ST_FAT_RD2) begin
        if (next_ok) begin
          current_cluster <= next_cl;
        end else begin
          walk_active <= 1'b0;
        end
      end
      if (state == ST_CL_MUL) begin
        bytes_left <= bytes_left - take;
        if (bytes_left == take) begin
          walk_active <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    base <= 24'(reserved_sectors) + (24'(fat_copies) * 24'(fat_size_sectors))
          + 24'((13'(root_entry_count) + 13'(FCSW_DIR_PER_SEC - 1)) >> $clog2(FCSW_DIR_PER_SEC));
    if (state == ST_FAT_RD1) begin
      fat_lo <= mem_rdata;
    end
    if (state == ST_IDLE && in_acc) begin
      empty_done <= (req_type == REQ_START) && (byte_count == 32'd0);
      empty_err  <= ((req_type == REQ_START) && (byte_count != 32'd0) && !start_ok)
                  || ((req_type == REQ_CONTINUE) && walk_active && off_bad);
    end
    if (state == ST_FAT_RD2) begin
      empty_done <= 1'b0;
      empty_err  <= 1'b1;
    end
    if (state == ST_CL_MUL) begin
      cl_off    <= 19'(current_cluster - FCSW_FIRST_DATA) * 19'(spc);
      nsec      <= 7'((take[15:0] + 16'(FCSW_SECTOR_BYTES - 1)) >> FCSW_SECTOR_SHIFT);
      walk_done <= bytes_left == take;
      k         <= '0;
    end
    if (state == ST_CL_ADD) begin
      lsn <= base + 24'(cl_off);
    end
    if (state == ST_DIV1_WAIT && drsp.done) begin
      cyl     <= drsp.quotient;
      cyl_rem <= drsp.remainder;
    end
    if (out_load) begin
      if (state == ST_EMIT) begin
        sector_valid   <= 1'b1;
        logical_sector <= lsn;
        cylinder       <= cyl;
        head           <= drsp.quotient[0];
        track_sector   <= 6'(drsp.remainder + 7'd1);
        last_of_run    <= k_last;
        chain_done     <= k_last && walk_done;
        chain_error    <= 1'b0;
        k              <= k + 7'd1;
        lsn            <= lsn + 24'd1;
      end else begin
        sector_valid   <= 1'b0;
        logical_sector <= '0;
        cylinder       <= '0;
        head           <= 1'b0;
        track_sector   <= '0;
        last_of_run    <= 1'b1;
        chain_done     <= empty_done;
        chain_error    <= empty_err;
      end
    end
  end

  fcsw_fat_ram #(.DEPTH(FAT_BYTES)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fat_address[AW-1:0]),
    .wdata (fat_value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fcsw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  `FCSW_ASSERT_NOW(a_div_done_wait, clk, rst, drsp.done, (state == ST_DIV1_WAIT) || (state == ST_DIV2_WAIT))
  `FCSW_ASSERT_NEXT(a_last_to_idle, clk, rst, (state == ST_EMIT) && out_load && k_last, state == ST_IDLE)
  `FCSW_ASSERT_NOW(a_sector_nonzero, clk, rst, out_valid && sector_valid, track_sector != 6'd0)

endmodule

// File: rtl/fcsw_fat_ram.sv
// fat byte store, one write port and one registered read port
module fcsw_fat_ram import fcsw_pkg::*; #(
  parameter int DEPTH = FCSW_FAT_BYTES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fcsw_div.sv
// shared restoring divider, one quotient bit per cycle
module fcsw_div import fcsw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(FCSW_DIV_BITS);

  logic [FCSW_DIV_BITS-1:0] dvd;
  logic [FCSW_DSR_BITS-1:0] rem;
  logic [FCSW_DSR_BITS-1:0] dsr;
  logic [CW-1:0]            cnt;
  logic                     busy;
  logic                     done;
  logic [FCSW_DSR_BITS:0]   trial;
  logic                     fits;

  always_comb begin
    trial = {rem, dvd[FCSW_DIV_BITS-1]};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
      cnt <= CW'(FCSW_DIV_BITS - 1);
    end else if (busy) begin
      dvd <= {dvd[FCSW_DIV_BITS-2:0], fits};
      rem <= fits ? FCSW_DSR_BITS'(trial - {1'b0, dsr}) : trial[FCSW_DSR_BITS-1:0];
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = dvd;
  assign rsp.remainder = rem;

endmodule

// File: sim/fat12_chain_sector_walker_tb.sv
// testbench for the fat12 chain sector walker: directed and random requests against a predictor
module fat12_chain_sector_walker_tb import fcsw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        sector_valid;
    logic [23:0] logical_sector;
    logic [23:0] cylinder;
    logic        head;
    logic [5:0]  track_sector;
    logic        last_of_run;
    logic        chain_done;
    logic        chain_error;
  } sector_rec_t;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 220;
  localparam int DRAIN_CYCLES = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [12:0] fat_address = '0;
  logic [7:0]  fat_value = '0;
  logic [11:0] first_cluster = '0;
  logic [31:0] byte_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        sector_valid;
  logic [23:0] logical_sector;
  logic [23:0] cylinder;
  logic        head;
  logic [5:0]  track_sector;
  logic        last_of_run;
  logic        chain_done;
  logic        chain_error;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // predictor state
  logic [7:0]  fat_image [FCSW_FAT_BYTES];
  bit          fat_known [FCSW_FAT_BYTES];
  logic [11:0] walk_cluster;
  logic [31:0] walk_bytes_left;
  bit          walk_on;
  logic [15:0] geo_reserved;
  logic [2:0]  geo_copies;
  logic [4:0]  geo_fat_size;
  logic [11:0] geo_root_cnt;
  logic [6:0]  geo_spc;
  logic [5:0]  geo_spt;
  logic [1:0]  geo_sides;

  sector_rec_t sector_expect_q [$];
  int  fail_count = 0;
  int  items_sent = 0;
  bit  idle_on = 1'b1;
  int  long_hold = 0;
  int  recv_burst = 0;

  fat12_chain_sector_walker dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .fat_address(fat_address), .fat_value(fat_value),
    .first_cluster(first_cluster), .byte_count(byte_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .sector_valid(sector_valid), .logical_sector(logical_sector), .cylinder(cylinder),
    .head(head), .track_sector(track_sector), .last_of_run(last_of_run),
    .chain_done(chain_done), .chain_error(chain_error),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

  // receiver side: random stall bursts plus an occasional long hold
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_stall = 1'b1;
        long_hold--;
      end else if (recv_burst > 0) begin
        out_stall = 1'b1;
        recv_burst--;
      end else begin
        out_stall = 1'b0;
        if (idle_on && $urandom_range(0, 5) == 0) recv_burst = $urandom_range(1, 9);
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    sector_rec_t e;
    if (!rst && out_valid && !out_stall) begin
      if (sector_expect_q.size() == 0) begin
        $error("unexpected result transaction: logical_sector %0h", logical_sector);
        fail_count++;
      end else begin
        e = sector_expect_q.pop_front();
        check_field("sector_valid", e.sector_valid, sector_valid);
        check_field("logical_sector", e.logical_sector, logical_sector);
        check_field("cylinder", e.cylinder, cylinder);
        check_field("head", e.head, head);
        check_field("track_sector", e.track_sector, track_sector);
        check_field("last_of_run", e.last_of_run, last_of_run);
        check_field("chain_done", e.chain_done, chain_done);
        check_field("chain_error", e.chain_error, chain_error);
      end
    end
  end

  function automatic void push_empty(bit done_f, bit err_f);
    sector_rec_t r;
    r = '{default: '0};
    r.last_of_run = 1'b1;
    r.chain_done = done_f;
    r.chain_error = err_f;
    sector_expect_q.push_back(r);
  endfunction

  function automatic bit data_cluster(logic [12:0] c);
    return c >= 13'(FCSW_FIRST_DATA) && c <= 13'(FCSW_LAST_DATA);
  endfunction

  function automatic logic [12:0] fat_entry(logic [11:0] c);
    int unsigned off;
    logic [15:0] w;
    off = c + (c >> 1);
    if (off + 1 >= FCSW_FAT_BYTES) return 13'h1000;
    w = {fat_image[off + 1], fat_image[off]};
    return c[0] ? 13'(w >> 4) : 13'(w[11:0]);
  endfunction

  function automatic void predict_sectors();
    int unsigned spc, spt, sides, per_cyl, root_secs, first, take, nsec, lsn, rem;
    bit done_f;
    sector_rec_t r;
    spc = geo_spc == 0 ? 1 : (geo_spc > 64 ? 64 : geo_spc);
    spt = geo_spt == 0 ? 1 : geo_spt;
    sides = geo_sides == 0 ? 1 : (geo_sides > 2 ? 2 : geo_sides);
    per_cyl = spt * sides;
    root_secs = (geo_root_cnt + 15) / 16;
    first = geo_reserved + geo_copies * geo_fat_size + root_secs + (walk_cluster - 2) * spc;
    take = walk_bytes_left > spc * 512 ? spc * 512 : walk_bytes_left;
    nsec = (take + 511) / 512;
    walk_bytes_left -= take;
    done_f = walk_bytes_left == 0;
    if (done_f) walk_on = 1'b0;
    for (int unsigned k = 0; k < nsec; k++) begin
      lsn = (first + k) & 32'hffffff;
      rem = lsn % per_cyl;
      r.sector_valid = 1'b1;
      r.logical_sector = 24'(lsn);
      r.cylinder = 24'(lsn / per_cyl);
      r.head = 1'((rem / spt) & 1);
      r.track_sector = 6'((rem % spt) + 1);
      r.last_of_run = k + 1 == nsec;
      r.chain_done = k + 1 == nsec && done_f;
      r.chain_error = 1'b0;
      sector_expect_q.push_back(r);
    end
  endfunction

  function automatic void predict_request(logic [1:0] rt, logic [12:0] addr, logic [7:0] val,
                                          logic [11:0] cl, logic [31:0] cnt);
    logic [12:0] nxt;
    case (rt)
      REQ_LOAD: begin
        fat_image[addr] = val;
        fat_known[addr] = 1'b1;
      end
      REQ_START: begin
        walk_bytes_left = cnt;
        walk_on = 1'b0;
        if (cnt == 0) push_empty(1'b1, 1'b0);
        else if (!data_cluster({1'b0, cl})) push_empty(1'b0, 1'b1);
        else begin
          walk_cluster = cl;
          walk_on = 1'b1;
          predict_sectors();
        end
      end
      REQ_CONTINUE: begin
        if (!walk_on) push_empty(1'b0, 1'b0);
        else begin
          nxt = fat_entry(walk_cluster);
          if (!data_cluster(nxt)) begin
            walk_on = 1'b0;
            push_empty(1'b0, 1'b1);
          end else begin
            walk_cluster = nxt[11:0];
            predict_sectors();
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [1:0] rt, logic [12:0] addr, logic [7:0] val,
                              logic [11:0] cl, logic [31:0] cnt);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = rt;
    fat_address = addr;
    fat_value = val;
    first_cluster = cl;
    byte_count = cnt;
    do @(posedge clk); while (in_stall);
    predict_request(rt, addr, val, cl, cnt);
    if (rt != REQ_UNUSED) items_sent++;
  endtask

  task automatic send_load(logic [12:0] addr, logic [7:0] val);
    send_request(REQ_LOAD, addr, val, 12'($urandom), $urandom);
  endtask

  task automatic send_start(logic [11:0] cl, logic [31:0] cnt);
    send_request(REQ_START, 13'($urandom), 8'($urandom), cl, cnt);
  endtask

  task automatic send_continue();
    send_request(REQ_CONTINUE, 13'($urandom), 8'($urandom), 12'($urandom), $urandom);
  endtask

  // writes a 12-bit fat entry, keeping the neighbor's nibble
  task automatic set_entry(logic [11:0] c, logic [11:0] v);
    int unsigned off;
    logic [15:0] w;
    off = c + (c >> 1);
    w = {fat_known[off + 1] ? fat_image[off + 1] : 8'h00, fat_known[off] ? fat_image[off] : 8'h00};
    if (c[0]) w = {v, w[3:0]};
    else w = {w[15:12], v};
    send_load(13'(off), w[7:0]);
    send_load(13'(off + 1), w[15:8]);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sector_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_RESERVED: geo_reserved = data;
      REG_COPIES:   geo_copies = data[2:0];
      REG_FAT_SIZE: geo_fat_size = data[4:0];
      REG_ROOT_CNT: geo_root_cnt = data[11:0];
      REG_SPC:      geo_spc = data[6:0];
      REG_SPT:      geo_spt = data[5:0];
      REG_SIDES:    geo_sides = data[1:0];
      default: ;
    endcase
  endtask

  task automatic write_geometry(logic [15:0] rsv, logic [15:0] cp, logic [15:0] fs,
                                logic [15:0] rc, logic [15:0] spc, logic [15:0] spt,
                                logic [15:0] sd);
    drain();
    write_reg(REG_RESERVED, rsv);
    write_reg(REG_COPIES, cp);
    write_reg(REG_FAT_SIZE, fs);
    write_reg(REG_ROOT_CNT, rc);
    write_reg(REG_SPC, spc);
    write_reg(REG_SPT, spt);
    write_reg(REG_SIDES, sd);
  endtask

  function automatic logic [11:0] pick_next();
    case ($urandom_range(0, 9))
      0: return 12'($urandom_range(12'hff8, 12'hfff));
      1: return 12'hff7;
      2: return 12'($urandom_range(0, 1));
      default: return 12'($urandom_range(2, 12'hff6));
    endcase
  endfunction

  function automatic logic [11:0] pick_cluster();
    case ($urandom_range(0, 7))
      0: return 12'h002;
      1: return 12'hff6;
      default: return 12'($urandom_range(2, 12'hff6));
    endcase
  endfunction

  task automatic continue_walk();
    int unsigned off;
    off = walk_cluster + (walk_cluster >> 1);
    if (walk_on && (!fat_known[off] || !fat_known[off + 1] || $urandom_range(0, 2) != 0))
      set_entry(walk_cluster, pick_next());
    send_continue();
  endtask

  // default geometry, zero length, bad start clusters, odd and even packing
  task automatic test_directed();
    send_start(12'h002, 32'd0);
    send_continue();
    send_start(12'h000, 32'd100);
    send_start(12'h001, 32'd100);
    send_start(12'hff7, 32'd100);
    send_start(12'hfff, 32'd100);
    send_request(REQ_UNUSED, 13'h1fff, 8'hff, 12'hfff, 32'hffffffff);
    set_entry(12'h002, 12'h003);
    set_entry(12'h003, 12'hfff);
    send_start(12'h002, 32'd3000);
    send_continue();
    send_continue();
    send_continue();
    set_entry(12'hff6, 12'hff7);
    send_start(12'hff6, 32'hffffffff);
    send_continue();
    send_load(13'h1fff, 8'hff);
    send_load(13'h0000, 8'h00);
  endtask

  // extreme geometry, both ends, with a few short chains each
  task automatic test_geometry_extremes();
    write_geometry(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    write_reg(REG_UNUSED, 16'h5a5a);
    repeat (3) begin
      send_start(pick_cluster(), $urandom_range(1, 70000));
      repeat (2) continue_walk();
    end
    write_geometry(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    repeat (4) begin
      send_start(pick_cluster(), $urandom_range(1, 2000));
      repeat (3) continue_walk();
    end
  endtask

  // output held off long enough for the block to stall its input
  task automatic test_backpressure();
    write_geometry(16'd1, 16'd2, 16'd9, 16'd224, 16'd2, 16'd18, 16'd2);
    @(negedge clk);
    long_hold = 500;
    repeat (3) begin
      send_start(pick_cluster(), $urandom_range(1, 4096));
      continue_walk();
    end
  endtask

  task automatic test_random();
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ((items_sent - target + RANDOM_ITEMS) % 80 == 0)
        write_geometry(16'($urandom), 16'($urandom_range(1, 4)), 16'($urandom_range(1, 16)),
                       16'($urandom_range(0, 4095)), 16'($urandom_range(1, 8)),
                       16'($urandom_range(1, 63)), 16'($urandom_range(1, 2)));
      if (target - items_sent < 60) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0: send_load(13'($urandom), 8'($urandom));
        1: continue_walk();
        2: send_start(12'($urandom), $urandom);
        3: send_request(REQ_UNUSED, 13'($urandom), 8'($urandom), 12'($urandom), $urandom);
        default: begin
          send_start(pick_cluster(), $urandom_range(0, 9) == 0 ? $urandom :
                     $urandom_range(1, 12000));
          repeat ($urandom_range(1, 5)) continue_walk();
        end
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < FCSW_FAT_BYTES; i++) begin
      fat_image[i] = 8'h00;
      fat_known[i] = 1'b0;
    end
    walk_cluster = '0;
    walk_bytes_left = '0;
    walk_on = 1'b0;
    geo_reserved = 16'd1;
    geo_copies = 3'd2;
    geo_fat_size = 5'd2;
    geo_root_cnt = 12'd112;
    geo_spc = 7'd2;
    geo_spt = 6'd9;
    geo_sides = 2'd2;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_geometry_extremes();
    test_backpressure();
    test_random();
    drain();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
